### rtl/psc_pkg.sv
package psc_pkg;

  localparam int SHADE_LEVELS = 41;
  localparam int CODE_W       = 12;
  localparam int DIST_W       = 10;

  localparam logic [5:0]  SHADE_MID   = 6'd20;
  localparam logic [5:0]  SHADE_FIRST = 6'd1;
  localparam logic [5:0]  SHADE_LAST  = 6'(SHADE_LEVELS - 2);
  localparam logic [4:0]  SHADE_DIV   = 5'd20;

  // x / 20 == ((x >> 2) * 3277) >> 14 for x below 65536
  localparam logic [11:0] DIV20_MUL   = 12'd3277;
  localparam int          DIV20_SHIFT = 14;

  localparam logic [23:0] COLOR_BLACK = 24'h000000;
  localparam logic [7:0]  CHAN_MAX    = 8'hFF;
  localparam logic [CODE_W-1:0] ENTRY_STRIDE = 12'd100;

  typedef struct packed {
    logic        command;
    logic [23:0] color;
    logic        exact_mode;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] color_code;
    logic              found;
  } out_item_t;

  // one candidate handed to the shade unit
  typedef struct packed {
    logic              valid;
    logic              lighten;
    logic [4:0]        k;
    logic [CODE_W-1:0] code;
  } shade_req_t;

  typedef struct packed {
    logic              busy;
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [23:0]       color;
  } shade_rsp_t;

  function automatic logic [23:0] palette_color(input logic [4:0] idx);
    logic [23:0] c;
    unique case (idx)
      5'd0:  c = 24'h000000;
      5'd1:  c = 24'h0000FF;
      5'd2:  c = 24'h00FF00;
      5'd3:  c = 24'h00FFFF;
      5'd4:  c = 24'hFF0000;
      5'd5:  c = 24'hFF00FF;
      5'd6:  c = 24'hFFFF00;
      5'd7:  c = 24'hFFFFFF;
      5'd8:  c = 24'h000090;
      5'd9:  c = 24'h0000B0;
      5'd10: c = 24'h0000D0;
      5'd11: c = 24'h87CEFF;
      5'd12: c = 24'h009000;
      5'd13: c = 24'h00B000;
      5'd14: c = 24'h00D000;
      5'd15: c = 24'h009090;
      5'd16: c = 24'h00B0B0;
      5'd17: c = 24'h00D0D0;
      5'd18: c = 24'h900000;
      5'd19: c = 24'hB00000;
      5'd20: c = 24'hD00000;
      5'd21: c = 24'h900090;
      5'd22: c = 24'hB000B0;
      5'd23: c = 24'hD000D0;
      5'd24: c = 24'h803000;
      5'd25: c = 24'hA04000;
      5'd26: c = 24'hC06000;
      5'd27: c = 24'hFF8080;
      5'd28: c = 24'hFFA0A0;
      5'd29: c = 24'hFFC0C0;
      5'd30: c = 24'hFFE0E0;
      5'd31: c = 24'hFFD700;
    endcase
    return c;
  endfunction

endpackage

### rtl/psc_shade_unit.sv
module psc_shade_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_pkg::shade_req_t req,
  input  logic [23:0]        base,
  output psc_pkg::shade_rsp_t rsp
);

  // stage a: per channel product, stage b: divide by 20 and blend
  logic [12:0] prod_nxt [3];
  logic [12:0] prod_r   [3];
  logic [7:0]  chan_r   [3];
  logic        lighten_r;
  logic        valid_a_r;
  logic [psc_pkg::CODE_W-1:0] code_a_r;

  logic [23:0] color_nxt;
  logic [23:0] color_r;
  logic        valid_b_r;
  logic [psc_pkg::CODE_W-1:0] code_b_r;

  always_comb begin
    logic [7:0] c;
    logic [7:0] m;
    for (int j = 0; j < 3; j++) begin
      c = base[8*j +: 8];
      m = req.lighten ? (psc_pkg::CHAN_MAX - c) : c;
      prod_nxt[j] = 13'(m) * 13'(req.k);
    end
  end

  always_comb begin
    logic [22:0] scaled;
    logic [7:0]  quot;
    for (int j = 0; j < 3; j++) begin
      scaled = 23'(prod_r[j][12:2]) * 23'(psc_pkg::DIV20_MUL);
      quot   = scaled[psc_pkg::DIV20_SHIFT +: 8];
      color_nxt[8*j +: 8] = lighten_r ? (chan_r[j] + quot) : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      valid_a_r <= req.valid;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod_r[j] <= prod_nxt[j];
      chan_r[j] <= base[8*j +: 8];
    end
    lighten_r <= req.lighten;
    code_a_r  <= req.code;
    color_r   <= color_nxt;
    code_b_r  <= code_a_r;
  end

  assign rsp.busy  = valid_a_r;
  assign rsp.valid = valid_b_r;
  assign rsp.code  = code_b_r;
  assign rsp.color = color_r;

endmodule

### rtl/palette_shade_color_matcher_top.sv
// channel | handshake           | payload
// in      | in_valid / in_stall | in_data  : command, color, exact_mode
// out     | out_valid/out_stall | out_data : color_code, found
//
// one candidate color per cycle through the shade unit (multiply, divide by 20)
// and the distance compare; the candidate count sets the time per item:
// pen: PALETTE_ENTRIES candidates; exact fill: 39*PALETTE_ENTRIES;
// nearest fill: 39*(PALETTE_ENTRIES-1) + 1 (1210 at 32 entries)
// in_stall is high from acceptance until the result moves to the output register
// the output register holds a result under out_stall while the next item is taken
// synchronous active-low reset clears the sequencer and the valid bits only
module palette_shade_color_matcher_top #(
  parameter int PALETTE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psc_pkg::out_item_t  out_data
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic        cmd_r;
  logic        exact_r;
  logic [23:0] color_r;
  logic [IDX_W-1:0] entry_r, entry_nxt;
  logic [5:0]  shade_r, shade_nxt;
  logic [psc_pkg::DIST_W-1:0] best_r, best_nxt;
  logic [psc_pkg::CODE_W-1:0] code_r, code_nxt;

  logic out_valid_r, out_valid_nxt;
  psc_pkg::out_item_t out_data_r;

  logic accept, last_cand, adv_entry, load_out;
  logic [23:0] base;
  logic        is_black;
  psc_pkg::shade_req_t req;
  psc_pkg::shade_rsp_t rsp;
  logic [psc_pkg::DIST_W-1:0] cand_dist;
  logic take;

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign in_stall  = (state_r != ST_IDLE);
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // candidate order: pen walks entries at shade 20; fill walks shades 1..39 per
  // entry, nearest fill taking entry 0 only unshaded
  assign last_cand = (entry_r == LAST_IDX) && (!cmd_r || shade_r == psc_pkg::SHADE_LAST);
  assign adv_entry = !cmd_r || (shade_r == psc_pkg::SHADE_LAST)
                     || (entry_r == '0 && !exact_r);

  assign base     = psc_pkg::palette_color(5'(entry_r));
  assign is_black = (base == psc_pkg::COLOR_BLACK);

  always_comb begin
    req.valid = (state_r == ST_RUN);
    req.code  = cmd_r ? (psc_pkg::CODE_W'(entry_r) * psc_pkg::ENTRY_STRIDE
                         + psc_pkg::CODE_W'(shade_r))
                      : psc_pkg::CODE_W'(entry_r);
    if (is_black) begin
      // black mirrors dark shades into lighter ones, light shades stay black
      if (shade_r < psc_pkg::SHADE_MID) begin
        req.lighten = 1'b1;
        req.k       = 5'(psc_pkg::SHADE_MID - shade_r);
      end else begin
        req.lighten = 1'b0;
        req.k       = psc_pkg::SHADE_DIV;
      end
    end else if (shade_r <= psc_pkg::SHADE_MID) begin
      req.lighten = 1'b0;
      req.k       = 5'(shade_r);
    end else begin
      req.lighten = 1'b1;
      req.k       = 5'(shade_r - psc_pkg::SHADE_MID);
    end
  end

  psc_shade_unit u_shade (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .base (base),
    .rsp  (rsp)
  );

  always_comb begin
    logic [7:0] a, b;
    logic [psc_pkg::DIST_W-1:0] sum;
    sum = '0;
    for (int j = 0; j < 3; j++) begin
      a = color_r[8*j +: 8];
      b = rsp.color[8*j +: 8];
      sum = sum + psc_pkg::DIST_W'((a > b) ? (a - b) : (b - a));
    end
    cand_dist = sum;
  end

  // exact mode only counts a zero distance; strict less keeps the first one
  assign take = rsp.valid && (cand_dist < best_r) && (!exact_r || cand_dist == '0);

  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    shade_nxt     = shade_r;
    best_nxt      = best_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      best_nxt = cand_dist;
      code_nxt = rsp.code;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          entry_nxt = '0;
          shade_nxt = (in_data.command && in_data.exact_mode) ? psc_pkg::SHADE_FIRST
                                                              : psc_pkg::SHADE_MID;
          best_nxt  = '1;
          code_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (last_cand) begin
          state_nxt = ST_DRAIN;
        end else if (adv_entry) begin
          entry_nxt = entry_r + 1'b1;
          shade_nxt = cmd_r ? psc_pkg::SHADE_FIRST : psc_pkg::SHADE_MID;
        end else begin
          shade_nxt = shade_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!rsp.busy && !rsp.valid) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    shade_r <= shade_nxt;
    best_r  <= best_nxt;
    code_r  <= code_nxt;
    if (accept) begin
      cmd_r   <= in_data.command;
      exact_r <= in_data.exact_mode;
      color_r <= in_data.color;
    end
    if (load_out) begin
      out_data_r.color_code <= code_r;
      out_data_r.found      <= !exact_r || (best_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rsp.busy && !rsp.valid))
    else $error("shade pipeline busy while idle");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (entry_r <= LAST_IDX))
    else $error("entry counter out of range");

  a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (shade_r >= psc_pkg::SHADE_FIRST
                             && shade_r <= psc_pkg::SHADE_LAST))
    else $error("shade counter out of range");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_RUN))
    else $error("accepted item did not start the search");

  a_miss_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.color_code == '0))
    else $error("exact miss with nonzero code");
`endif

endmodule

### bench/palette_shade_color_matcher_top_tb.sv
`timescale 1ns / 100ps

module palette_shade_color_matcher_top_tb;

  localparam int ENTRIES       = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 1300;
  localparam int LOG_LIMIT     = 40;
  localparam longint RUN_LIMIT_NS = 64'd6_000_000;

  localparam logic CMD_PEN      = 1'b0;
  localparam logic CMD_FILL     = 1'b1;
  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_EXACT   = 1'b1;

  localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
  localparam logic [5:0]  SHADE_TOP   = 6'd40;

  // entry 31 first, entry 0 last
  localparam logic [ENTRIES-1:0][23:0] PALETTE_ROM = {
    24'hFFD700, 24'hFFE0E0, 24'hFFC0C0, 24'hFFA0A0,
    24'hFF8080, 24'hC06000, 24'hA04000, 24'h803000,
    24'hD000D0, 24'hB000B0, 24'h900090, 24'hD00000,
    24'hB00000, 24'h900000, 24'h00D0D0, 24'h00B0B0,
    24'h009090, 24'h00D000, 24'h00B000, 24'h009000,
    24'h87CEFF, 24'h0000D0, 24'h0000B0, 24'h000090,
    24'hFFFFFF, 24'hFFFF00, 24'hFF00FF, 24'hFF0000,
    24'h00FFFF, 24'h00FF00, 24'h0000FF, 24'h000000
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  psc_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  psc_pkg::out_item_t out_data;

  psc_pkg::out_item_t pending_matches[$];
  int        mismatch_count;
  bit        quiet;
  logic      hold_req;

  palette_shade_color_matcher_top #(
    .PALETTE_ENTRIES(ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [23:0] shade_color(input logic [23:0] base, input logic [5:0] s);
    logic [5:0]  k;
    logic [7:0]  v;
    logic [23:0] res;
    k = s;
    if (k == psc_pkg::SHADE_MID || k > SHADE_TOP) return base;
    // black mirrors its dark shades into light ones
    if (base == psc_pkg::COLOR_BLACK) begin
      if (k > psc_pkg::SHADE_MID) return psc_pkg::COLOR_BLACK;
      if (k == 6'd0) return COLOR_WHITE;
      k = SHADE_TOP - k;
    end
    if (base == COLOR_WHITE) begin
      if (k > psc_pkg::SHADE_MID) return COLOR_WHITE;
      if (k == 6'd0) return psc_pkg::COLOR_BLACK;
    end
    if (k == 6'd0) return psc_pkg::COLOR_BLACK;
    if (k == SHADE_TOP) return COLOR_WHITE;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      v = base[c*8 +: 8];
      if (k < psc_pkg::SHADE_MID)
        res[c*8 +: 8] = 8'((16'(v) * k) / psc_pkg::SHADE_DIV);
      else
        res[c*8 +: 8] = v + 8'((16'(psc_pkg::CHAN_MAX - v) * (k - psc_pkg::SHADE_MID))
                               / psc_pkg::SHADE_DIV);
    end
    return res;
  endfunction

  function automatic logic [9:0] color_distance(input logic [23:0] a, input logic [23:0] b);
    logic [9:0] sum;
    logic [7:0] x;
    logic [7:0] y;
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      x = a[c*8 +: 8];
      y = b[c*8 +: 8];
      sum += (x > y) ? 10'(x - y) : 10'(y - x);
    end
    return sum;
  endfunction

  function automatic psc_pkg::out_item_t match_color(input psc_pkg::in_item_t item);
    psc_pkg::out_item_t res;
    logic [9:0]  best;
    logic [9:0]  d;
    logic [23:0] cand;
    res.color_code = '0;
    res.found      = 1'b1;
    if (item.command == CMD_PEN) begin
      if (item.exact_mode == MODE_EXACT) begin
        res.found = 1'b0;
        for (int i = 0; i < ENTRIES && !res.found; i++)
          if (item.color == PALETTE_ROM[i]) begin
            res.color_code = psc_pkg::CODE_W'(i);
            res.found      = 1'b1;
          end
      end else begin
        best = color_distance(item.color, PALETTE_ROM[0]);
        for (int i = 1; i < ENTRIES; i++) begin
          d = color_distance(item.color, PALETTE_ROM[i]);
          if (d < best) begin
            best           = d;
            res.color_code = psc_pkg::CODE_W'(i);
          end
        end
      end
    end else if (item.exact_mode == MODE_EXACT) begin
      res.found = 1'b0;
      for (int i = 0; i < ENTRIES && !res.found; i++)
        for (int s = psc_pkg::SHADE_FIRST; s <= psc_pkg::SHADE_LAST && !res.found; s++)
          if (item.color == shade_color(PALETTE_ROM[i], 6'(s))) begin
            res.color_code = psc_pkg::CODE_W'(i) * psc_pkg::ENTRY_STRIDE
                             + psc_pkg::CODE_W'(s);
            res.found      = 1'b1;
          end
    end else begin
      // entry 0 only takes part unshaded
      res.color_code = psc_pkg::CODE_W'(psc_pkg::SHADE_MID);
      best = color_distance(item.color, PALETTE_ROM[0]);
      for (int i = 1; i < ENTRIES; i++)
        for (int s = psc_pkg::SHADE_FIRST; s <= psc_pkg::SHADE_LAST; s++) begin
          cand = shade_color(PALETTE_ROM[i], 6'(s));
          d    = color_distance(item.color, cand);
          if (d < best) begin
            best           = d;
            res.color_code = psc_pkg::CODE_W'(i) * psc_pkg::ENTRY_STRIDE
                             + psc_pkg::CODE_W'(s);
          end
        end
    end
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic psc_pkg::in_item_t make_item(input logic cmd, input logic [23:0] rgb,
                                                  input logic mode);
    psc_pkg::in_item_t it;
    it.command    = cmd;
    it.color      = rgb;
    it.exact_mode = mode;
    return it;
  endfunction

  // mostly palette colors or their shades, some one bit off, some pure noise
  function automatic psc_pkg::in_item_t random_item(input logic cmd);
    psc_pkg::in_item_t it;
    logic [4:0] idx;
    logic [5:0] shade;
    int         pick;
    idx   = 5'($urandom_range(0, ENTRIES - 1));
    shade = 6'($urandom_range(psc_pkg::SHADE_FIRST, psc_pkg::SHADE_LAST));
    pick  = $urandom_range(0, 9);
    it.command    = cmd;
    it.exact_mode = 1'($urandom_range(0, 1));
    if (pick < 3) begin
      it.color = 24'($urandom());
    end else begin
      it.color = (cmd == CMD_FILL) ? shade_color(PALETTE_ROM[idx], shade) : PALETTE_ROM[idx];
      if (pick >= 7) it.color = it.color ^ (24'h1 << $urandom_range(0, 23));
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    // keep the log short when the block is badly off
    if (mismatch_count < LOG_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic offer_color(input psc_pkg::in_item_t item);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_matches.push_back(match_color(item));
  endtask

  task automatic run_directed_lookups();
    offer_color(make_item(CMD_PEN, 24'h000000, MODE_NEAREST));
    offer_color(make_item(CMD_PEN, 24'hFFFFFF, MODE_NEAREST));
    offer_color(make_item(CMD_PEN, 24'hFF0000, MODE_NEAREST));
    offer_color(make_item(CMD_PEN, 24'h0000FF, MODE_NEAREST));
    // equally far from entries 0 and 8, the earlier one wins
    offer_color(make_item(CMD_PEN, 24'h000048, MODE_NEAREST));
    offer_color(make_item(CMD_PEN, 24'h87CEFF, MODE_EXACT));
    offer_color(make_item(CMD_PEN, 24'hFFD700, MODE_EXACT));
    offer_color(make_item(CMD_PEN, 24'h00FF00, MODE_EXACT));
    offer_color(make_item(CMD_PEN, 24'h000000, MODE_EXACT));
    offer_color(make_item(CMD_PEN, 24'h123456, MODE_EXACT));
    offer_color(make_item(CMD_FILL, 24'h000000, MODE_NEAREST));
    offer_color(make_item(CMD_FILL, 24'hFFFFFF, MODE_NEAREST));
    offer_color(make_item(CMD_FILL, 24'h00FF00, MODE_NEAREST));
    offer_color(make_item(CMD_FILL, 24'h7F7F7F, MODE_NEAREST));
    offer_color(make_item(CMD_FILL, shade_color(PALETTE_ROM[11], 6'd39), MODE_NEAREST));
    // mirrored dark shade of black
    offer_color(make_item(CMD_FILL, 24'h7F7F7F, MODE_EXACT));
    offer_color(make_item(CMD_FILL, 24'h000000, MODE_EXACT));
    offer_color(make_item(CMD_FILL, 24'hFFFFFF, MODE_EXACT));
    offer_color(make_item(CMD_FILL, shade_color(PALETTE_ROM[7], 6'd5), MODE_EXACT));
    offer_color(make_item(CMD_FILL, shade_color(PALETTE_ROM[31], 6'd1), MODE_EXACT));
    offer_color(make_item(CMD_FILL, shade_color(PALETTE_ROM[24], 6'd33), MODE_EXACT));
    offer_color(make_item(CMD_FILL, 24'h123457, MODE_EXACT));
  endtask

  task automatic run_random_pen(input int count);
    for (int n = 0; n < count; n++) offer_color(random_item(CMD_PEN));
  endtask

  task automatic run_random_fill(input int count);
    for (int n = 0; n < count; n++) offer_color(random_item(CMD_FILL));
  endtask

  task automatic run_back_to_back(input int count);
    quiet = 1'b1;
    for (int n = 0; n < count; n++) offer_color(random_item(1'($urandom_range(0, 1))));
    quiet = 1'b0;
  endtask

  // a result waits in the output register and the next in ST_DONE while the sink holds off
  task automatic run_output_hold();
    quiet = 1'b1;
    hold_req <= 1'b1;
    for (int n = 0; n < 12; n++) offer_color(random_item(CMD_PEN));
    quiet = 1'b0;
  endtask

  initial begin : result_sink
    int n;
    bit held;
    out_stall = 1'b0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = idle_len();
        if (n == 0) n = 1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    psc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected item code %0d found %0b",
                                  out_data.color_code, out_data.found));
      end else begin
        want = pending_matches.pop_front();
        if (out_data.color_code !== want.color_code)
          report_mismatch($sformatf("color_code got %0d want %0d",
                                    out_data.color_code, want.color_code));
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", out_data.found, want.found));
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL palette_shade_color_matcher_top");
    $finish;
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    hold_req       = 1'b0;
    quiet          = 1'b0;
    mismatch_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed_lookups();
    run_random_pen(200);
    run_random_fill(140);
    run_back_to_back(100);
    run_output_hold();
    run_random_fill(10);
    in_valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS palette_shade_color_matcher_top");
    end else begin
      $display("FAIL palette_shade_color_matcher_top");
    end
    $finish;
  end

endmodule

### sim.f
rtl/psc_pkg.sv
rtl/psc_shade_unit.sv
rtl/palette_shade_color_matcher_top.sv
bench/palette_shade_color_matcher_top_tb.sv
